### hw/rtl/tcwu_pkg.sv
package tcwu_pkg;

    // operation codes carried in the operation field
    localparam logic [2:0] OP_RESTART = 3'd0;
    localparam logic [2:0] OP_ACK     = 3'd1;
    localparam logic [2:0] OP_QINC    = 3'd2;
    localparam logic [2:0] OP_QDEC    = 3'd3;
    localparam logic [2:0] OP_LOSS    = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SEGMENT_SIZE      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INITIAL_WINDOW    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INITIAL_THRESHOLD = 2'd2;

    // reset values
    localparam logic [15:0] RST_SEGMENT_SIZE      = 16'd536;
    localparam logic [31:0] RST_INITIAL_WINDOW    = 32'd536;
    localparam logic [31:0] RST_INITIAL_THRESHOLD = 32'hFFFF_FFFF;
    localparam logic [15:0] RST_WINDOW            = 16'd536;

    // serial divider: dividend is seg*seg, always 32 bits
    localparam int DIV_DIVIDEND_BITS = 32;
    localparam int DIV_CNT_BITS      = 5;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] segments_acked;
        logic [15:0] queued_packets;
        logic [15:0] operating_point;
        logic [31:0] bytes_in_flight;
    } t_cwu_in;

    typedef struct packed {
        logic [31:0] window;
        logic [31:0] threshold;
        logic        in_slow_start;
    } t_cwu_out;

endpackage

### hw/rtl/tcwu_div.sv
module tcwu_div #(
    parameter int WINDOW_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [tcwu_pkg::DIV_DIVIDEND_BITS-1:0] i_dividend,
    input  logic [WINDOW_BITS-1:0]                i_divisor,
    output logic                                  o_done,
    output logic [tcwu_pkg::DIV_DIVIDEND_BITS-1:0] o_quotient
);
    import tcwu_pkg::*;

    localparam logic [DIV_CNT_BITS-1:0] LAST_STEP = DIV_CNT_BITS'(DIV_DIVIDEND_BITS - 1);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [DIV_CNT_BITS-1:0]      r_cnt, n_cnt;
    logic [WINDOW_BITS-1:0]       r_rem, n_rem;
    logic [WINDOW_BITS-1:0]       r_divisor, n_divisor;
    logic [DIV_DIVIDEND_BITS-1:0] r_quot, n_quot;

    logic [WINDOW_BITS:0] shifted;
    logic [WINDOW_BITS:0] diff;
    logic                 fits;

    // one restoring step: shift in next dividend bit, trial subtract
    assign shifted = {r_rem, r_quot[DIV_DIVIDEND_BITS-1]};
    assign diff    = shifted - {1'b0, r_divisor};
    assign fits    = shifted >= {1'b0, r_divisor};

    always_comb begin
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_divisor = r_divisor;
        n_quot    = r_quot;
        if (i_start) begin
            n_busy    = 1'b1;
            n_cnt     = '0;
            n_rem     = '0;
            n_divisor = i_divisor;
            n_quot    = i_dividend;
        end else if (r_busy) begin
            n_rem  = fits ? diff[WINDOW_BITS-1:0] : shifted[WINDOW_BITS-1:0];
            n_quot = {r_quot[DIV_DIVIDEND_BITS-2:0], fits};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
        r_quot    <= n_quot;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

### hw/rtl/tcp_congestion_window_update.sv
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_in_data  (t_cwu_in)
// out       output     o_out_valid / i_out_ready  o_out_data (t_cwu_out)
// cfg       input      i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// one transaction at a time: after acceptance an item passes through the execute state
// and then sits in the output stage; restart, queue and loss ops go from execute
// straight to output, an ack passes through a check state as well. an ack that reaches
// congestion avoidance with a nonzero window runs the 32-step serial divider for
// seg*seg/window and then an add state before the output stage.
// o_in_ready is low until the result transaction completes; a stalled output holds.
// synchronous active-low reset loads window 536, threshold all ones, flag set.
module tcp_congestion_window_update #(
    parameter int WINDOW_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  tcwu_pkg::t_cwu_in                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output tcwu_pkg::t_cwu_out                   o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [tcwu_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [tcwu_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import tcwu_pkg::*;

    localparam int EW = (WINDOW_BITS > 32) ? WINDOW_BITS : 32;
    localparam logic [WINDOW_BITS-1:0] WIN_MAX = '1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_CHECK = 6'b000100,
        S_DIV   = 6'b001000,
        S_ADD   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    logic [15:0]            r_seg, n_seg;
    logic [31:0]            r_init_win, n_init_win;
    logic [31:0]            r_init_thr, n_init_thr;
    logic [WINDOW_BITS-1:0] r_cw, n_cw;
    logic [31:0]            r_thr, n_thr;
    logic                   r_flag, n_flag;
    t_cwu_in                r_in, n_in;
    logic [15:0]            r_acked, n_acked;
    logic [31:0]            r_prod, n_prod;

    logic [EW-1:0]          cw_ext;
    logic [EW-1:0]          thr_ext;
    logic [16:0]            seg2;
    logic [31:0]            seg_sq;
    logic [15:0]            half_op;
    logic                   q_above;
    logic [WINDOW_BITS-1:0] tent_cw;
    logic [WINDOW_BITS-1:0] dec_cw;
    logic [30:0]            half_flight;
    logic                   ca_needed;
    logic [31:0]            quot_eff;
    logic                   div_start;
    logic                   div_done;
    logic [31:0]            div_quot;

    // saturating add onto the window
    function automatic logic [WINDOW_BITS-1:0] win_add(
        input logic [WINDOW_BITS-1:0] a,
        input logic [31:0]            b
    );
        logic [EW:0] s;
        s = (EW+1)'(a) + (EW+1)'(b);
        if (s > (EW+1)'(WIN_MAX)) begin
            return WIN_MAX;
        end
        return s[WINDOW_BITS-1:0];
    endfunction

    // shared operands and compares
    assign cw_ext      = EW'(r_cw);
    assign thr_ext     = EW'(r_thr);
    assign seg2        = {r_seg, 1'b0};
    assign seg_sq      = 32'(r_seg) * 32'(r_seg);
    assign half_op     = {1'b0, r_in.operating_point[15:1]};
    assign q_above     = r_in.queued_packets > half_op;
    assign tent_cw     = win_add(r_cw, {16'b0, r_seg});
    assign dec_cw      = (cw_ext >= EW'(seg2)) ? (r_cw - WINDOW_BITS'(r_seg)) : r_cw;
    assign half_flight = r_in.bytes_in_flight[31:1];
    assign ca_needed   = (cw_ext >= thr_ext) && (r_acked != 16'd0);
    assign quot_eff    = (div_quot == 32'd0) ? 32'd1 : div_quot;

    // divider launch and completion
    assign div_start = (r_state == S_CHECK) && ca_needed && (r_cw != '0);

    tcwu_div #(
        .WINDOW_BITS(WINDOW_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_cw),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // sequencer and register updates
    always_comb begin
        n_state    = r_state;
        n_seg      = r_seg;
        n_init_win = r_init_win;
        n_init_thr = r_init_thr;
        n_cw       = r_cw;
        n_thr      = r_thr;
        n_flag     = r_flag;
        n_in       = r_in;
        n_acked    = r_acked;
        n_prod     = r_prod;

        // configuration writes
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEGMENT_SIZE:      n_seg      = i_cfg_data[15:0];
                CFG_INITIAL_WINDOW:    n_init_win = i_cfg_data;
                CFG_INITIAL_THRESHOLD: n_init_thr = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_acked = i_in_data.segments_acked;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                case (r_in.operation)
                    OP_RESTART: begin
                        n_cw   = (EW'(r_init_win) > EW'(WIN_MAX)) ? WIN_MAX
                                                               : WINDOW_BITS'(r_init_win);
                        n_thr  = r_init_thr;
                        n_flag = 1'b1;
                    end
                    OP_ACK: begin
                        // slow-start step, then maybe congestion avoidance
                        if ((cw_ext < thr_ext) && (r_acked != 16'd0)) begin
                            n_cw    = tent_cw;
                            n_acked = r_acked - 16'd1;
                        end
                        n_prod  = seg_sq;
                        n_state = S_CHECK;
                    end
                    OP_QINC: begin
                        if ((EW'(tent_cw) >= thr_ext) || q_above) begin
                            n_flag = 1'b0;
                        end else begin
                            n_cw = tent_cw;
                        end
                    end
                    OP_QDEC: begin
                        n_cw = dec_cw;
                        if ((EW'(dec_cw) < thr_ext) && !q_above) begin
                            n_flag = 1'b1;
                        end
                    end
                    OP_LOSS: begin
                        n_thr = (32'(seg2) > {1'b0, half_flight}) ? 32'(seg2)
                                                                  : {1'b0, half_flight};
                    end
                    default: ;
                endcase
            end
            S_CHECK: begin
                if (ca_needed) begin
                    if (r_cw == '0) begin
                        // zero window: quotient taken as all ones
                        n_cw    = WIN_MAX;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_DIV;
                    end
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_cw    = win_add(r_cw, quot_eff);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_seg      <= RST_SEGMENT_SIZE;
            r_init_win <= RST_INITIAL_WINDOW;
            r_init_thr <= RST_INITIAL_THRESHOLD;
            r_cw       <= WINDOW_BITS'(RST_WINDOW);
            r_thr      <= '1;
            r_flag     <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_seg      <= n_seg;
            r_init_win <= n_init_win;
            r_init_thr <= n_init_thr;
            r_cw       <= n_cw;
            r_thr      <= n_thr;
            r_flag     <= n_flag;
        end
        r_in    <= n_in;
        r_acked <= n_acked;
        r_prod  <= n_prod;
    end

    // handshake and result payload
    assign o_in_ready               = (r_state == S_IDLE);
    assign o_out_valid              = (r_state == S_OUT);
    assign o_out_data.window        = cw_ext[31:0];
    assign o_out_data.threshold     = r_thr;
    assign o_out_data.in_slow_start = r_flag;

endmodule

### tb/sv/tb_tcp_congestion_window_update.sv
module tb_tcp_congestion_window_update;
    timeunit 1ns;
    timeprecision 1ps;

    import tcwu_pkg::*;

    // codes the block treats as no-ops
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    localparam logic [63:0] WIN_MAX   = 64'hFFFF_FFFF;
    localparam int          PHASES    = 8;
    localparam int          PHASE_LEN = 250;

    typedef struct {
        bit          load_cfg;
        logic [15:0] seg;
        logic [31:0] init_win;
        logic [31:0] init_thr;
        t_cwu_in     item;
        bit          typed;
        t_cwu_out    result;
    } t_row;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_cwu_in     in_data   = '0;
    logic        out_ready = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_SEGMENT_SIZE;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_cwu_out    o_out_data;

    logic        idle_en = 1'b1;
    int          fail_count = 0;

    // window state and settings as the block should hold them
    logic [63:0] cur_window = 64'd536;
    logic [63:0] cur_thresh = 64'hFFFF_FFFF;
    logic        cur_flag   = 1'b1;
    logic [15:0] cur_seg      = RST_SEGMENT_SIZE;
    logic [31:0] cur_init_win = RST_INITIAL_WINDOW;
    logic [31:0] cur_init_thr = RST_INITIAL_THRESHOLD;

    t_cwu_out pending_results[$];
    t_row     directed_rows[$];

    tcp_congestion_window_update u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // saturating window addition
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        if (a >= WIN_MAX || b > WIN_MAX - a)
            return WIN_MAX;
        return a + b;
    endfunction

    // applies one operation to the window state, returns the state after it
    function automatic t_cwu_out advance_window(input t_cwu_in it);
        logic [63:0] seg;
        logic [63:0] acked;
        logic [63:0] queued;
        logic [63:0] half_op;
        logic [63:0] tent;
        logic [63:0] quot;
        logic [63:0] twice_seg;
        logic [63:0] half_flight;
        t_cwu_out    res;
        seg     = {48'd0, cur_seg};
        acked   = {48'd0, it.segments_acked};
        queued  = {48'd0, it.queued_packets};
        half_op = {48'd0, it.operating_point} >> 1;
        case (it.operation)
            OP_RESTART: begin
                cur_window = {32'd0, cur_init_win};
                cur_thresh = {32'd0, cur_init_thr};
                cur_flag   = 1'b1;
            end
            OP_ACK: begin
                // slow-start step, then congestion avoidance if acks remain
                if (cur_window < cur_thresh && acked >= 1) begin
                    cur_window = sat_add(cur_window, seg);
                    acked      = acked - 1;
                end
                if (cur_window >= cur_thresh && acked > 0) begin
                    if (cur_window == 0)
                        quot = '1;
                    else
                        quot = (seg * seg) / cur_window;
                    if (quot < 1)
                        quot = 1;
                    cur_window = sat_add(cur_window, quot);
                end
            end
            OP_QINC: begin
                tent = sat_add(cur_window, seg);
                if (tent >= cur_thresh || queued > half_op)
                    cur_flag = 1'b0;
                else
                    cur_window = tent;
            end
            OP_QDEC: begin
                if (cur_window >= (seg << 1))
                    cur_window = cur_window - seg;
                if (cur_window < cur_thresh && queued <= half_op)
                    cur_flag = 1'b1;
            end
            OP_LOSS: begin
                twice_seg   = seg << 1;
                half_flight = {32'd0, it.bytes_in_flight} >> 1;
                cur_thresh  = (twice_seg > half_flight) ? twice_seg : half_flight;
            end
            default: ;
        endcase
        res.window        = cur_window[31:0];
        res.threshold     = cur_thresh[31:0];
        res.in_slow_start = cur_flag;
        return res;
    endfunction

    // directed table builders
    task automatic row_cfg(input logic [15:0] seg, input logic [31:0] iw, input logic [31:0] it);
        t_row r;
        r          = '{default: '0};
        r.load_cfg = 1'b1;
        r.seg      = seg;
        r.init_win = iw;
        r.init_thr = it;
        directed_rows.push_back(r);
    endtask

    task automatic row_item(input logic [2:0] op, input logic [15:0] acked,
                            input logic [15:0] queued, input logic [15:0] opp,
                            input logic [31:0] flight, input bit typed,
                            input logic [31:0] win, input logic [31:0] thr,
                            input logic flag);
        t_row r;
        r                      = '{default: '0};
        r.item.operation       = op;
        r.item.segments_acked  = acked;
        r.item.queued_packets  = queued;
        r.item.operating_point = opp;
        r.item.bytes_in_flight = flight;
        r.typed                = typed;
        r.result.window        = win;
        r.result.threshold     = thr;
        r.result.in_slow_start = flag;
        directed_rows.push_back(r);
    endtask

    // writes all three registers while the block is idle
    task automatic load_config(input logic [15:0] seg, input logic [31:0] iw,
                               input logic [31:0] it);
        cur_seg      = seg;
        cur_init_win = iw;
        cur_init_thr = it;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SEGMENT_SIZE;
        cfg_data  <= {16'd0, seg};
        @(posedge clk);
        cfg_index <= CFG_INITIAL_WINDOW;
        cfg_data  <= iw;
        @(posedge clk);
        cfg_index <= CFG_INITIAL_THRESHOLD;
        cfg_data  <= it;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // drops valid and waits until every expected result has come out
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // one input transaction; valid is left high for a back-to-back follower
    task automatic send_item(input t_cwu_in item, input bit typed, input t_cwu_out typed_res);
        t_cwu_out predicted;
        if (idle_en && $urandom_range(0, 99) < 13) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (idle_en && $urandom_range(0, 99) < 13);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!o_in_ready);
        predicted = advance_window(item);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // output stall
    always @(posedge clk) begin
        out_ready <= !(idle_en && $urandom_range(0, 99) < 13);
    end

    // result checking
    always @(posedge clk) begin
        t_cwu_out want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result transaction: window %h threshold %h flag %b",
                             o_out_data.window, o_out_data.threshold,
                             o_out_data.in_slow_start);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.window !== want.window
                        || o_out_data.threshold !== want.threshold
                        || o_out_data.in_slow_start !== want.in_slow_start) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected %h/%h/%b got %h/%h/%b",
                                 want.window, want.threshold, want.in_slow_start,
                                 o_out_data.window, o_out_data.threshold,
                                 o_out_data.in_slow_start);
                end
            end
        end
    end

    // stimulus
    initial begin
        t_cwu_in     item;
        logic [15:0] seg;
        logic [31:0] iw;
        logic [31:0] it;
        int unsigned pick;
        logic [2:0]  spare_ops[3];
        spare_ops = '{OP_SPARE_A, OP_SPARE_B, OP_SPARE_C};

        // after reset: seg 536, window 536, threshold all ones
        row_item(OP_SPARE_A, 16'd0, 16'd0, 16'd0, 32'd0, 1'b1, 32'd536, 32'hFFFF_FFFF, 1'b1);
        row_item(OP_SPARE_C, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                 1'b1, 32'd536, 32'hFFFF_FFFF, 1'b1);
        row_item(OP_RESTART, 16'd0, 16'd0, 16'd0, 32'd0, 1'b1, 32'd536, 32'hFFFF_FFFF, 1'b1);
        row_item(OP_ACK, 16'd0, 16'd0, 16'd0, 32'd0, 1'b1, 32'd536, 32'hFFFF_FFFF, 1'b1);
        row_item(OP_ACK, 16'd1, 16'd0, 16'd0, 32'd0, 1'b1, 32'd1072, 32'hFFFF_FFFF, 1'b1);
        row_item(OP_ACK, 16'hFFFF, 16'd0, 16'd0, 32'd0, 1'b1, 32'd1608, 32'hFFFF_FFFF, 1'b1);
        row_item(OP_LOSS, 16'd0, 16'd0, 16'd0, 32'd0, 1'b1, 32'd1608, 32'd1072, 1'b1);
        row_item(OP_ACK, 16'd2, 16'd0, 16'd0, 32'd0, 1'b0, '0, '0, 1'b0);
        row_item(OP_ACK, 16'hFFFF, 16'd0, 16'd0, 32'd0, 1'b0, '0, '0, 1'b0);
        row_item(OP_QINC, 16'd0, 16'd0, 16'd0, 32'd0, 1'b0, '0, '0, 1'b0);
        row_item(OP_QDEC, 16'd0, 16'd0, 16'hFFFF, 32'd0, 1'b0, '0, '0, 1'b0);
        row_item(OP_LOSS, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0);
        row_item(OP_QINC, 16'd0, 16'd1, 16'd3, 32'd0, 1'b0, '0, '0, 1'b0);
        row_item(OP_QINC, 16'd0, 16'd2, 16'd3, 32'd0, 1'b0, '0, '0, 1'b0);
        row_item(OP_QDEC, 16'd0, 16'd1, 16'd2, 32'd0, 1'b0, '0, '0, 1'b0);
        // window saturation and a reverted increase at the top
        row_cfg(16'hFFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        row_item(OP_RESTART, 16'd0, 16'd0, 16'd0, 32'd0, 1'b1, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
                 1'b1);
        row_item(OP_ACK, 16'd1, 16'd0, 16'd0, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        row_item(OP_QINC, 16'd0, 16'd0, 16'd0, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        row_item(OP_LOSS, 16'd0, 16'd0, 16'd0, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'h0001_FFFE, 1'b0);
        row_item(OP_ACK, 16'd3, 16'd0, 16'd0, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'h0001_FFFE, 1'b0);
        // zero segment size and zero window in congestion avoidance
        row_cfg(16'd0, 32'd0, 32'd0);
        row_item(OP_RESTART, 16'd0, 16'd0, 16'd0, 32'd0, 1'b1, 32'd0, 32'd0, 1'b1);
        row_item(OP_ACK, 16'd1, 16'd0, 16'd0, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'd0, 1'b1);
        row_item(OP_QDEC, 16'd0, 16'd0, 16'd0, 32'd0, 1'b0, '0, '0, 1'b0);
        row_item(OP_QINC, 16'd0, 16'd0, 16'd0, 32'd0, 1'b0, '0, '0, 1'b0);
        row_item(OP_LOSS, 16'd0, 16'd0, 16'd0, 32'd1, 1'b0, '0, '0, 1'b0);

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].load_cfg) begin
                drain();
                load_config(directed_rows[i].seg, directed_rows[i].init_win,
                            directed_rows[i].init_thr);
            end else begin
                send_item(directed_rows[i].item, directed_rows[i].typed,
                          directed_rows[i].result);
            end
        end

        // random phases, each with its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            idle_en <= (phase != 3);
            case (phase)
                0: begin
                    seg = 16'd1;
                    iw  = 32'd0;
                    it  = 32'hFFFF_FFFF;
                end
                PHASES - 1: begin
                    seg = 16'hFFFF;
                    iw  = 32'hFFFF_FFFF;
                    it  = 32'hFFFF_FFFF;
                end
                5: begin
                    seg = 16'($urandom_range(0, 65535));
                    iw  = $urandom();
                    it  = $urandom();
                end
                default: begin
                    seg = 16'($urandom_range(1, 1460));
                    iw  = seg * $urandom_range(0, 10);
                    it  = iw + seg * $urandom_range(1, 40);
                end
            endcase
            load_config(seg, iw, it);

            for (int n = 0; n < PHASE_LEN; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    item.operation = OP_RESTART;
                else if (pick < 44)
                    item.operation = OP_ACK;
                else if (pick < 64)
                    item.operation = OP_QINC;
                else if (pick < 84)
                    item.operation = OP_QDEC;
                else if (pick < 94)
                    item.operation = OP_LOSS;
                else
                    item.operation = spare_ops[$urandom_range(0, 2)];

                pick = $urandom_range(0, 99);
                if (pick < 60)
                    item.segments_acked = 16'($urandom_range(0, 3));
                else if (pick < 90)
                    item.segments_acked = 16'($urandom_range(0, 64));
                else
                    item.segments_acked = 16'($urandom());

                if ($urandom_range(0, 99) < 70) begin
                    item.queued_packets  = 16'($urandom_range(0, 40));
                    item.operating_point = 16'($urandom_range(0, 40));
                end else begin
                    item.queued_packets  = 16'($urandom());
                    item.operating_point = 16'($urandom());
                end

                item.bytes_in_flight = $urandom() >> $urandom_range(0, 31);
                send_item(item, 1'b0, '0);
            end
        end

        // wait for the tail and let any stray result show up
        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // overall time limit
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/tcwu_pkg.sv
hw/rtl/tcwu_div.sv
hw/rtl/tcp_congestion_window_update.sv
tb/sv/tb_tcp_congestion_window_update.sv
